FILE: hdl/spq_pkg.sv
// shared types and constants for the sorted array priority queue
`default_nettype none
package spq_pkg;

  // stored word width and reported count width
  localparam int WORD_W = 32;
  localparam int COUNT_OUT_W = 4;
  localparam int DEPTH_DEF = 8;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [WORD_W-1:0] value;
  } spq_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/spq_cell.sv
// one cell of the sorted chain: holds one word, compares and shifts with its neighbors
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                     clk,
  input  wire spq_cmd_t                 cmd,
  input  wire logic                     occupied,
  input  wire logic                     prev_lt,
  input  wire logic signed [WORD_W-1:0] prev_value,
  input  wire logic signed [WORD_W-1:0] next_value,
  output logic                          lt,
  output logic signed [WORD_W-1:0]      value,
  output logic signed [WORD_W-1:0]      value_next
);

  // this entry stays in place on insert when it is smaller than the new word
  assign lt = occupied && (value < cmd.value);

  // choose the word held after this step
  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (lt) begin
        value_next = value;
      end else if (prev_lt) begin
        value_next = cmd.value;
      end else begin
        value_next = prev_value;
      end
    end else if (cmd.rem) begin
      value_next = next_value;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

FILE: hdl/sorted_array_priority_queue.sv
// top level of the sorted array priority queue: cell chain, count and result register
`default_nettype none
// Minimum priority queue of up to DEPTH signed 32-bit words, kept sorted in a chain
// of compare-and-shift cells with the smallest word in the first cell. Every accepted
// word (insert or remove) yields one result word: the removed value, a status (ok,
// insert dropped because full, remove on empty), the count, empty and full flags and
// the smallest stored value after the step. All cells compare against the incoming value
// in parallel and shift by one place, so a new item is accepted in every cycle while the
// result register is free or being read. The result is registered and appears in the
// cycle after its item is accepted. The entry_count field is 4 bits wide and wraps for
// counts above 15.
module sorted_array_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic signed [WORD_W-1:0]      value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [WORD_W-1:0]           removed_value,
  output logic [1:0]                         status,
  output logic [COUNT_OUT_W-1:0]             entry_count,
  output logic                               is_empty,
  output logic                               is_full,
  output logic signed [WORD_W-1:0]           min_value
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             accept;
  logic             empty_now;
  logic             full_now;
  spq_cmd_t         cmd;
  status_t          status_next;
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] cell_lt;

  logic signed [WORD_W-1:0] cell_value [DEPTH];
  logic signed [WORD_W-1:0] cell_value_next [DEPTH];

  // handshake: take a word whenever the result register is free or drains now
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  assign empty_now = (count == '0);
  assign full_now = (count == CW'(DEPTH));

  // command to the chain, gated so that a dropped insert or empty remove changes nothing
  always_comb begin
    cmd.ins = accept && (action == ACT_INSERT) && !full_now;
    cmd.rem = accept && (action == ACT_REMOVE) && !empty_now;
    cmd.value = value;
  end

  // occupancy of each cell from the count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (count > CW'(i));
    end
  end

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     p_lt;
    logic signed [WORD_W-1:0] p_value;
    logic signed [WORD_W-1:0] n_value;

    if (g == 0) begin : g_head
      assign p_lt = 1'b1;
      assign p_value = '0;
    end else begin : g_mid
      assign p_lt = cell_lt[g-1];
      assign p_value = cell_value[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign n_value = '0;
    end else begin : g_body
      assign n_value = cell_value[g+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ[g]),
      .prev_lt    (p_lt),
      .prev_value (p_value),
      .next_value (n_value),
      .lt         (cell_lt[g]),
      .value      (cell_value[g]),
      .value_next (cell_value_next[g])
    );
  end

  // count update and status
  always_comb begin
    count_next = count;
    status_next = ST_OK;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.rem) begin
      count_next = count - CW'(1);
    end
    if (accept && (action == ACT_INSERT) && full_now) begin
      status_next = ST_FULL;
    end else if (accept && (action == ACT_REMOVE) && empty_now) begin
      status_next = ST_EMPTY;
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= cmd.rem ? cell_value[0] : '0;
      status <= status_next;
      entry_count <= COUNT_OUT_W'(count_next);
      is_empty <= (count_next == '0);
      is_full <= (count_next == CW'(DEPTH));
      min_value <= (count_next != '0) ? cell_value_next[0] : '0;
    end
  end

endmodule
`default_nettype wire

FILE: bench/spq_result_checker.sv
// result checker for the sorted array priority queue: shadow queue, expected words, compare
`default_nettype none
module spq_result_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic                     action,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic signed [WORD_W-1:0] removed_value,
  input  wire logic [1:0]               status,
  input  wire logic [COUNT_OUT_W-1:0]   entry_count,
  input  wire logic                     is_empty,
  input  wire logic                     is_full,
  input  wire logic signed [WORD_W-1:0] min_value,
  output int                            mismatches,
  output int                            outstanding
);

  // one predicted result word
  typedef struct {
    logic signed [WORD_W-1:0] removed;
    status_t                  st;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     empty;
    logic                     full;
    logic signed [WORD_W-1:0] smallest;
  } queue_result_t;

  // shadow copy of the queue, descending, smallest at index shadow_count - 1
  logic signed [WORD_W-1:0] shadow_store [DEPTH];
  int                       shadow_count;
  queue_result_t            expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    shadow_count = 0;
  end

  // apply one accepted word to the shadow queue and describe the outcome
  function automatic queue_result_t step_shadow_queue(logic act,
                                                      logic signed [WORD_W-1:0] val);
    queue_result_t r;
    int            pos;
    r.removed = '0;
    r.st      = ST_OK;
    if (act == ACT_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        // smaller words move toward the tail, new word lands after equal ones
        pos = shadow_count;
        while (pos > 0 && val > shadow_store[pos-1]) begin
          shadow_store[pos] = shadow_store[pos-1];
          pos--;
        end
        shadow_store[pos] = val;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        shadow_count--;
        r.removed = shadow_store[shadow_count];
      end
    end
    r.count    = shadow_count[COUNT_OUT_W-1:0];
    r.empty    = (shadow_count == 0);
    r.full     = (shadow_count == DEPTH);
    r.smallest = (shadow_count > 0) ? shadow_store[shadow_count-1] : '0;
    return r;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // results first: a word leaving now belongs to an item taken at an earlier edge
  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with no expectation waiting, removed %0d status %0d",
                   $time, removed_value, status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("removed_value", want.removed, removed_value);
          check_field("status", want.st, status);
          check_field("entry_count", want.count, entry_count);
          check_field("is_empty", want.empty, is_empty);
          check_field("is_full", want.full, is_full);
          check_field("min_value", want.smallest, min_value);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(step_shadow_queue(action, value));
      end
    end
    outstanding = expected_results.size();
  end

endmodule
`default_nettype wire

FILE: bench/sorted_array_priority_queue_test.sv
// testbench top for the sorted array priority queue: stimulus, watchdog and verdict
`default_nettype none
module sorted_array_priority_queue_test
  import spq_pkg::*;
();

  localparam int DEPTH = DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 234;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = ACT_INSERT;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] removed_value;
  logic [1:0]               status;
  logic [COUNT_OUT_W-1:0]   entry_count;
  logic                     is_empty;
  logic                     is_full;
  logic signed [WORD_W-1:0] min_value;

  int mismatches;
  int outstanding;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  sorted_array_priority_queue #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .removed_value(removed_value), .status(status), .entry_count(entry_count),
    .is_empty(is_empty), .is_full(is_full), .min_value(min_value)
  );

  spq_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .removed_value(removed_value), .status(status), .entry_count(entry_count),
    .is_empty(is_empty), .is_full(is_full), .min_value(min_value),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // present one word at a falling edge and hold it until taken
  task automatic send_word(logic act, logic signed [WORD_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // small values so equal keys are common, extremes, and most often full-range words
  function automatic logic signed [WORD_W-1:0] pick_value();
    logic signed [WORD_W-1:0] v;
    case ($urandom_range(3))
      0: v = $signed($urandom_range(8)) - 4;
      1: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh7FFF_FFFE;
          default: v = 32'sh8000_0001;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // bursts with a drifting insert share so the queue swings between empty and full
  task automatic random_words(int total);
    int left;
    int bias;
    int burst;
    left = total;
    while (left > 0) begin
      case ($urandom_range(2))
        0: bias = 25;
        1: bias = 50;
        default: bias = 80;
      endcase
      burst = $urandom_range(10, 30);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_word(($urandom_range(99) < bias) ? ACT_INSERT : ACT_REMOVE, pick_value());
      end
      left -= burst;
    end
  endtask

  // sender holds off until every expected result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 22;
    recv_idle = 48;

    // remove on empty, extremes, equal values, insert on full, drain to empty
    send_word(ACT_REMOVE, 32'sh1234_5678);
    send_word(ACT_INSERT, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 32'sh8000_0000);
    send_word(ACT_INSERT, 32'sh0000_0000);
    send_word(ACT_INSERT, -32'sd1);
    send_word(ACT_INSERT, 32'sd1);
    send_word(ACT_INSERT, 32'sh0000_0000);
    send_word(ACT_INSERT, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 32'sh8000_0000);
    send_word(ACT_INSERT, 32'sd5);
    repeat (DEPTH + 1) send_word(ACT_REMOVE, -32'sd1);
    send_word(ACT_INSERT, 32'sh5555_5555);
    send_word(ACT_INSERT, 32'shAAAA_AAAA);
    drain_results();

    random_words(PHASE_WORDS);
    drain_results();

    send_idle = 48;
    recv_idle = 22;
    random_words(PHASE_WORDS);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    random_words(PHASE_WORDS);
    drain_results();

    repeat (6) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
